[rtl/pvpc_pkg.sv]
// ----------------------------------------------------------------------------
// PDF version and page count scanner package
// Shared constants, marker characters, result types and helper functions.
// ----------------------------------------------------------------------------
package pvpc_pkg;

  localparam int unsigned MAX_VERSION_CHARS = 8;
  localparam int unsigned CFG_ADDR_W        = 2;
  localparam int unsigned CFG_DATA_W        = 32;
  localparam logic [31:0] LIMIT_RESET       = 32'd2097152;

  localparam logic [CFG_ADDR_W-1:0] ADDR_BYTE_LIMIT = '0;

  localparam logic [2:0] HDR_LEN   = 3'd5;
  localparam logic [2:0] MARK_LEN  = 3'd6;

  localparam logic [7:0] CH_PCT    = 8'h25;  // '%'
  localparam logic [7:0] CH_SLASH  = 8'h2f;  // '/'
  localparam logic [7:0] CH_DOT    = 8'h2e;  // '.'
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;

  typedef struct packed {
    logic        found;
    logic [63:0] text;
    logic [3:0]  length;
    logic        truncated;
  } ver_res_t;

  typedef struct packed {
    logic        found;
    logic [30:0] count;
  } page_res_t;

  // "%PDF-"
  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = CH_PCT;
      3'd1:    ch = 8'h50;
      3'd2:    ch = 8'h44;
      3'd3:    ch = 8'h46;
      3'd4:    ch = 8'h2d;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // "/Pages"
  function automatic logic [7:0] pages_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = CH_SLASH;
      3'd1:    ch = 8'h50;
      3'd2:    ch = 8'h61;
      3'd3:    ch = 8'h67;
      3'd4:    ch = 8'h65;
      3'd5:    ch = 8'h73;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // "/Count"
  function automatic logic [7:0] count_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = CH_SLASH;
      3'd1:    ch = 8'h43;
      3'd2:    ch = 8'h6f;
      3'd3:    ch = 8'h75;
      3'd4:    ch = 8'h6e;
      3'd5:    ch = 8'h74;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Each marker opens with a symbol found nowhere else in it, so a mismatch
  // can only restart on that opening symbol.
  function automatic logic [2:0] match_step(input logic [2:0] len, input logic [7:0] c,
                                            input logic [7:0] expect_ch,
                                            input logic [7:0] first_ch);
    logic [2:0] nxt;
    if (c == expect_ch) begin
      nxt = len + 3'd1;
    end else if (c == first_ch) begin
      nxt = 3'd1;
    end else begin
      nxt = 3'd0;
    end
    return nxt;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

[rtl/pvpc_if.sv]
// ----------------------------------------------------------------------------
// Scanner channel interfaces
// Valid/ready channels for document words and for scan results.
// ----------------------------------------------------------------------------
interface pvpc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last;

  modport source (output valid, output data_byte, output has_byte, output last,
                  input ready);
  modport sink (input valid, input data_byte, input has_byte, input last,
                output ready);
endinterface

interface pvpc_out_if;
  logic        valid;
  logic        ready;
  logic        version_found;
  logic [63:0] version_text;
  logic [3:0]  version_length;
  logic        version_truncated;
  logic        page_count_found;
  logic [30:0] page_total;

  modport source (output valid, output version_found, output version_text,
                  output version_length, output version_truncated,
                  output page_count_found, output page_total, input ready);
  modport sink (input valid, input version_found, input version_text,
                input version_length, input version_truncated,
                input page_count_found, input page_total, output ready);
endinterface

[rtl/pvpc_ver_scan.sv]
// ----------------------------------------------------------------------------
// Version scanner
// Finds the first "%PDF-" and collects the digits and dots that follow.
// ----------------------------------------------------------------------------
module pvpc_ver_scan #(
  parameter int unsigned MAX_VERSION_CHARS = pvpc_pkg::MAX_VERSION_CHARS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic                clear,
  input  logic [7:0]          c,
  output pvpc_pkg::ver_res_t  res
);

  typedef enum logic [1:0] {
    V_SEARCH,
    V_COLLECT,
    V_DONE
  } ver_phase_t;

  localparam logic [3:0] MaxChars = 4'(MAX_VERSION_CHARS);

  ver_phase_t  phase_r, phase_nxt;
  logic [2:0]  match_r, match_nxt;
  logic [63:0] chars_r, chars_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        ovf_r, ovf_nxt;
  logic        found;

  always_comb begin
    phase_nxt = phase_r;
    match_nxt = match_r;
    chars_nxt = chars_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    if (step) begin
      case (phase_r)
        V_SEARCH: begin
          match_nxt = pvpc_pkg::match_step(match_r, c, pvpc_pkg::hdr_char(match_r),
                                           pvpc_pkg::CH_PCT);
          if (match_nxt == pvpc_pkg::HDR_LEN) begin
            match_nxt = 3'd0;
            phase_nxt = V_COLLECT;
          end
        end
        V_COLLECT: begin
          if (pvpc_pkg::is_digit(c) || (c == pvpc_pkg::CH_DOT)) begin
            if (cnt_r < MaxChars) begin
              chars_nxt[{cnt_r[2:0], 3'b000} +: 8] = c;
              cnt_nxt = cnt_r + 4'd1;
            end else begin
              ovf_nxt = 1'b1;
            end
          end else begin
            phase_nxt = V_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // The result reflects the state after the current word has been taken in.
  always_comb begin
    found         = (phase_nxt != V_SEARCH) && (cnt_nxt != 4'd0);
    res.found     = found;
    res.text      = found ? chars_nxt : 64'd0;
    res.length    = found ? cnt_nxt : 4'd0;
    res.truncated = found & ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      phase_r <= V_SEARCH;
      match_r <= 3'd0;
      chars_r <= 64'd0;
      cnt_r   <= 4'd0;
      ovf_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      match_r <= match_nxt;
      chars_r <= chars_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

[rtl/pvpc_page_scan.sv]
// ----------------------------------------------------------------------------
// Page count scanner
// Finds "/Pages", then "/Count", skips whitespace and accumulates the count.
// ----------------------------------------------------------------------------
module pvpc_page_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic                clear,
  input  logic [7:0]          c,
  output pvpc_pkg::page_res_t res
);

  typedef enum logic [2:0] {
    P_FIND_PAGES,
    P_FIND_COUNT,
    P_SKIP_SPACE,
    P_DIGITS,
    P_DONE
  } page_phase_t;

  page_phase_t phase_r, phase_nxt;
  logic [2:0]  match_r, match_nxt;
  logic [30:0] value_r, value_nxt;
  logic        ovf_r, ovf_nxt;
  logic        seen_r, seen_nxt;
  logic [34:0] wide_val;
  logic [34:0] acc;
  logic        add_digit;

  // value * 10 + digit; anything above 31 bits is an overflow.
  assign wide_val = {4'd0, value_r};
  assign acc      = (wide_val << 3) + (wide_val << 1) + 35'(c - pvpc_pkg::CH_ZERO);

  always_comb begin
    phase_nxt = phase_r;
    match_nxt = match_r;
    add_digit = 1'b0;
    if (step) begin
      case (phase_r)
        P_FIND_PAGES: begin
          match_nxt = pvpc_pkg::match_step(match_r, c, pvpc_pkg::pages_char(match_r),
                                           pvpc_pkg::CH_SLASH);
          if (match_nxt == pvpc_pkg::MARK_LEN) begin
            match_nxt = 3'd0;
            phase_nxt = P_FIND_COUNT;
          end
        end
        P_FIND_COUNT: begin
          match_nxt = pvpc_pkg::match_step(match_r, c, pvpc_pkg::count_char(match_r),
                                           pvpc_pkg::CH_SLASH);
          if (match_nxt == pvpc_pkg::MARK_LEN) begin
            match_nxt = 3'd0;
            phase_nxt = P_SKIP_SPACE;
          end
        end
        P_SKIP_SPACE: begin
          if (pvpc_pkg::is_digit(c)) begin
            add_digit = 1'b1;
            phase_nxt = P_DIGITS;
          end else if (!pvpc_pkg::is_space(c)) begin
            phase_nxt = P_DONE;
          end
        end
        P_DIGITS: begin
          if (pvpc_pkg::is_digit(c)) begin
            add_digit = 1'b1;
          end else begin
            phase_nxt = P_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    value_nxt = value_r;
    ovf_nxt   = ovf_r;
    seen_nxt  = seen_r | add_digit;
    if (add_digit && !ovf_r) begin
      if (acc[34:31] != 4'd0) begin
        ovf_nxt   = 1'b1;
        value_nxt = 31'd0;
      end else begin
        value_nxt = acc[30:0];
      end
    end
  end

  always_comb begin
    res.found = seen_nxt & ~ovf_nxt;
    res.count = (seen_nxt & ~ovf_nxt) ? value_nxt : 31'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      phase_r <= P_FIND_PAGES;
      match_r <= 3'd0;
      value_r <= 31'd0;
      ovf_r   <= 1'b0;
      seen_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      match_r <= match_nxt;
      value_r <= value_nxt;
      ovf_r   <= ovf_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule

[rtl/pdf_version_and_page_count_scanner_top.sv]
// ----------------------------------------------------------------------------
// PDF version and page count scanner
// A word marked last passes the input stage register, then the result register.
// One word per cycle, but a word marked last waits while an unread result is held.
// The result register lets the next word enter while a result waits.
// Reset (rst_n, synchronous): clears all scan state; byte_limit returns to 2097152.
// ----------------------------------------------------------------------------
module pdf_version_and_page_count_scanner_top #(
  parameter int unsigned MAX_VERSION_CHARS = pvpc_pkg::MAX_VERSION_CHARS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  pvpc_in_if.sink                             in_ch,
  pvpc_out_if.source                          out_ch,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [pvpc_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [pvpc_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [pvpc_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  logic [31:0] limit_r;
  logic [31:0] seen_r;

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_has_r;
  logic        s1_last_r;
  logic        s1_fire;
  logic        in_ready;
  logic        step;
  logic        clear;

  logic                out_valid_r;
  pvpc_pkg::ver_res_t  ver_res, ver_out_r;
  pvpc_pkg::page_res_t page_res, page_out_r;

  // Only one register, so every read returns it.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = limit_r;

  // A word carrying last can only move on when the result register is free or being read.
  assign s1_fire  = s1_valid_r && (!s1_last_r || !out_valid_r || out_ch.ready);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_ch.ready = in_ready;

  assign step  = s1_fire && s1_has_r && (seen_r < limit_r);
  assign clear = s1_fire && s1_last_r;

  pvpc_ver_scan #(
    .MAX_VERSION_CHARS(MAX_VERSION_CHARS)
  ) u_ver (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .clear (clear),
    .c     (s1_byte_r),
    .res   (ver_res)
  );

  pvpc_page_scan u_page (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .clear (clear),
    .c     (s1_byte_r),
    .res   (page_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= pvpc_pkg::LIMIT_RESET;
      seen_r      <= 32'd0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == pvpc_pkg::ADDR_BYTE_LIMIT)) begin
        limit_r <= cfg_pwdata;
      end
      if (clear) begin
        seen_r <= 32'd0;
      end else if (step) begin
        seen_r <= seen_r + 32'd1;
      end
      if (in_ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (clear) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ready) begin
      s1_byte_r <= in_ch.data_byte;
      s1_has_r  <= in_ch.has_byte;
      s1_last_r <= in_ch.last;
    end
    if (clear) begin
      ver_out_r  <= ver_res;
      page_out_r <= page_res;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.version_found     = ver_out_r.found;
  assign out_ch.version_text      = ver_out_r.text;
  assign out_ch.version_length    = ver_out_r.length;
  assign out_ch.version_truncated = ver_out_r.truncated;
  assign out_ch.page_count_found  = page_out_r.found;
  assign out_ch.page_total        = page_out_r.count;

endmodule
